// ----- rtl/ostb_pkg.sv -----
// Shared types and constants for the one-shot timer bank.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ostb_pkg;

    localparam int NUM_TIMERS          = 5;
    localparam int NUM_REGS            = 5;
    localparam int PERIOD_WIDTH        = 16;
    localparam int MODE_WIDTH          = 2;
    localparam int INDEX_WIDTH         = 3;
    localparam int CFG_INDEX_WIDTH     = 3;
    localparam int DEFAULT_COUNT_WIDTH = 16;

    // Reset periods, in ticks, one per timer
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET [NUM_REGS] = '{
        16'd150,   // repeat message
        16'd200,   // network timeout
        16'd100,   // wait bus sleep
        16'd2,     // immediate cycle
        16'd50     // message cycle
    };

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_TICK   = 2'd0,
        MODE_START  = 2'd1,
        MODE_CANCEL = 2'd2,
        MODE_CLEAR  = 2'd3
    } ostb_mode_t;

    // Per-timer command for one word
    typedef struct packed {
        logic tick;
        logic start;
        logic cancel;
        logic clear;
    } ostb_ctrl_t;

    // Per-timer flags after the update
    typedef struct packed {
        logic running;
        logic expired;
    } ostb_flags_t;

endpackage

`default_nettype wire

// ----- rtl/ostb_cfg_regs.sv -----
// Period registers of the timer bank, written through the plain write port.
// Depends on ostb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ostb_cfg_regs
    import ostb_pkg::*;
(
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0]              cfg_wr_index,
    input  wire logic [PERIOD_WIDTH-1:0]                 cfg_wr_data,
    output logic      [NUM_REGS-1:0][PERIOD_WIDTH-1:0]   periods
);

    logic [NUM_REGS-1:0][PERIOD_WIDTH-1:0] period_reg;

    // Load the addressed period; drop writes beyond the last register
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_REGS; i++) begin
            if (!aresetn) begin
                period_reg[i] <= PERIOD_RESET[i];
            end else if (cfg_wr_en && (cfg_wr_index == CFG_INDEX_WIDTH'(i))) begin
                period_reg[i] <= cfg_wr_data;
            end
        end
    end

    assign periods = period_reg;

endmodule

`default_nettype wire

// ----- rtl/ostb_timer.sv -----
// One one-shot timer: running bit, tick count and expired flag.
// Depends on ostb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ostb_timer
    import ostb_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire ostb_ctrl_t              ctrl,
    input  wire logic [PERIOD_WIDTH-1:0] period,
    output ostb_flags_t                  flags_next
);

    localparam int CMP_WIDTH =
        (COUNT_WIDTH + 1 > PERIOD_WIDTH) ? COUNT_WIDTH + 1 : PERIOD_WIDTH;
    // Count value whose increment reaches the all-ones limit
    localparam logic [COUNT_WIDTH-1:0] COUNT_LAST = {{(COUNT_WIDTH-1){1'b1}}, 1'b0};

    logic                   running_reg, running_next;
    logic                   expired_reg, expired_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [CMP_WIDTH-1:0]   count_inc;
    logic                   hit;

    // Expire when the incremented count meets the period or the count limit
    assign count_inc = CMP_WIDTH'(count_reg) + CMP_WIDTH'(1);
    assign hit       = (count_inc >= CMP_WIDTH'(period)) || (count_reg == COUNT_LAST);

    always_comb begin
        running_next = running_reg;
        expired_next = expired_reg;
        count_next   = count_reg;
        priority if (ctrl.tick) begin
            if (running_reg) begin
                if (hit) begin
                    count_next   = '0;
                    expired_next = 1'b1;
                    running_next = 1'b0;
                end else begin
                    count_next = count_reg + COUNT_WIDTH'(1);
                end
            end else begin
                count_next = '0;
            end
        end else if (ctrl.start) begin
            count_next   = '0;
            running_next = 1'b1;
            expired_next = 1'b0;
        end else if (ctrl.cancel) begin
            count_next   = '0;
            running_next = 1'b0;
            expired_next = 1'b0;
        end else if (ctrl.clear) begin
            expired_next = 1'b0;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            expired_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            running_reg <= running_next;
            expired_reg <= expired_next;
            count_reg   <= count_next;
        end
    end

    assign flags_next.running = running_next;
    assign flags_next.expired = expired_next;

endmodule

`default_nettype wire

// ----- rtl/one_shot_timer_bank.sv -----
// Top level of the one-shot timer bank: input register, timer slots, result register.
// Depends on ostb_pkg, ostb_cfg_regs and ostb_timer.
`timescale 1ns / 1ps
`default_nettype none

// A word is held in the input register, then its result in the result register.
// Throughput: one word per cycle unless m_ready holds a result back; while a
// result waits, the input register takes a new word only if it is empty. A tick
// word updates all five timers; a command word only the addressed one, if any.
// Reset (aresetn low, synchronous) stops all timers, clears counts and flags,
// empties both registers and loads the default periods.
module one_shot_timer_bank_core
    import ostb_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Configuration write port
    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_wr_index,
    input  wire logic [PERIOD_WIDTH-1:0]    cfg_wr_data,
    // Command words
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [MODE_WIDTH-1:0]      s_mode,
    input  wire logic [INDEX_WIDTH-1:0]     s_timer_index,
    // Result words
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [NUM_TIMERS-1:0]           m_expired_flags,
    output logic [NUM_TIMERS-1:0]           m_running_flags,
    output logic                            m_index_valid
);

    logic [NUM_REGS-1:0][PERIOD_WIDTH-1:0] periods;

    logic                   in_vld_reg;
    ostb_mode_t             mode_reg;
    logic [INDEX_WIDTH-1:0] index_reg;

    logic                   m_valid_reg;
    logic [NUM_TIMERS-1:0]  expired_flags_reg;
    logic [NUM_TIMERS-1:0]  running_flags_reg;
    logic                   index_valid_reg;

    logic                   out_free;
    logic                   fire;
    logic                   idx_ok;
    logic                   index_valid;
    ostb_ctrl_t             ctrl [NUM_TIMERS];
    ostb_flags_t            flags_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  expired_next;
    logic [NUM_TIMERS-1:0]  running_next;

    ostb_cfg_regs u_cfg_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .periods      (periods)
    );

    // Handshake: the word moves on when the result register is free or draining
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    // Hold the accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg  <= ostb_mode_t'(s_mode);
            index_reg <= s_timer_index;
        end
    end

    assign idx_ok      = (index_reg < INDEX_WIDTH'(NUM_TIMERS));
    assign index_valid = (mode_reg == MODE_TICK) || idx_ok;

    // Decode the word into one command per timer
    for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
        logic addressed;

        assign addressed     = fire && idx_ok && (index_reg == INDEX_WIDTH'(i));
        assign ctrl[i].tick   = fire && (mode_reg == MODE_TICK);
        assign ctrl[i].start  = addressed && (mode_reg == MODE_START);
        assign ctrl[i].cancel = addressed && (mode_reg == MODE_CANCEL);
        assign ctrl[i].clear  = addressed && (mode_reg == MODE_CLEAR);

        ostb_timer #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_timer (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl[i]),
            .period     (periods[i]),
            .flags_next (flags_next[i])
        );

        assign expired_next[i] = flags_next[i].expired;
        assign running_next[i] = flags_next[i].running;
    end

    // Result register: load on fire, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            expired_flags_reg <= expired_next;
            running_flags_reg <= running_next;
            index_valid_reg   <= index_valid;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_expired_flags = expired_flags_reg;
    assign m_running_flags = running_flags_reg;
    assign m_index_valid   = index_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/ostb_checker.sv -----
// Port-level assertions for the one-shot timer bank, bound to the top level.
// Depends on ostb_pkg and one_shot_timer_bank_core.
`timescale 1ns / 1ps
`default_nettype none

module ostb_checker
    import ostb_pkg::*;
(
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [NUM_TIMERS-1:0]      m_expired_flags,
    input wire logic [NUM_TIMERS-1:0]      m_running_flags,
    input wire logic                       m_index_valid
);

    // A stalled result word holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_expired_flags)
            && $stable(m_running_flags) && $stable(m_index_valid))
        else $error("result word changed while stalled");

    // No result straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A timer is never running and expired at once
    a_flags_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_expired_flags & m_running_flags) == '0))
        else $error("timer both running and expired");

    // Input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without back-pressure");

endmodule

bind one_shot_timer_bank_core ostb_checker u_ostb_checker (.*);

`default_nettype wire
